>>> src/sta_pkg.sv
// Shared types and constants of the sorted term accumulator.
`timescale 1ns / 1ps

package sta_pkg;

	localparam int COEF_W        = 32;
	localparam int EXP_W         = 16;
	localparam int CNT_W         = 7;
	localparam int DEF_MAX_TERMS = 64;

	typedef struct packed {
		logic signed [COEF_W-1:0] coef;
		logic signed [EXP_W-1:0]  expo;
	} term_t;

	typedef enum logic [2:0] {
		WS_NEW_CUR,
		WS_CARRY_CUR,
		WS_CARRY_CNT,
		WS_SUM_CUR,
		WS_RDATA_PREV
	} wr_sel_t;

	typedef struct packed {
		logic    load;
		logic    rd_en;
		logic    wr_en;
		wr_sel_t wr_sel;
		logic    carry_new;
		logic    carry_rdata;
		logic    sum_load;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    set_drop;
		logic    out_load;
		logic    out_term;
	} sta_cmd_t;

	typedef struct packed {
		logic op_dump;
		logic empty;
		logic full;
		logic at_end;
		logic exp_lt;
		logic exp_eq;
		logic sum_zero;
		logic out_free;
	} sta_status_t;

endpackage

>>> src/sta_dp.sv
// Datapath of the sorted term accumulator: term memory, walk index, carry and output word.
`timescale 1ns / 1ps

module sta_dp
	import sta_pkg::*;
#(
	parameter int MAX_TERMS = DEF_MAX_TERMS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  sta_cmd_t                 cmd,
	output sta_status_t              st,
	input  logic                     op,
	input  logic signed [COEF_W-1:0] coefficient,
	input  logic signed [EXP_W-1:0]  exponent,
	output logic signed [COEF_W-1:0] term_coefficient,
	output logic signed [EXP_W-1:0]  term_exponent,
	output logic                     term_valid,
	output logic                     last,
	output logic                     dropped,
	output logic [CNT_W-1:0]         term_count,
	output logic                     out_valid,
	input  logic                     out_stall
);

	localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_TERMS);

	term_t mem [MAX_TERMS];

	logic                     op_q;
	logic signed [COEF_W-1:0] coef_q;
	logic signed [EXP_W-1:0]  exp_q;
	logic [CNT_W-1:0]         idx_q;
	logic [AW-1:0]            cur_q;
	logic [CNT_W-1:0]         count_q;
	term_t                    carry_q;
	term_t                    rdata_q;
	logic signed [COEF_W-1:0] sum_q;
	logic                     dropped_q;

	logic                     out_valid_q;
	term_t                    out_term_q;
	logic                     out_tv_q;
	logic                     out_last_q;
	logic                     out_drop_q;
	logic [CNT_W-1:0]         out_cnt_q;

	logic [AW-1:0]            wa;
	term_t                    wd;
	logic signed [COEF_W:0]   sum_wide;
	logic signed [COEF_W-1:0] sum_sat;

	// Saturating add of the matched coefficient and the new one.
	assign sum_wide = {rdata_q.coef[COEF_W-1], rdata_q.coef} + {coef_q[COEF_W-1], coef_q};

	always_comb begin
		if (sum_wide[COEF_W] != sum_wide[COEF_W-1]) begin
			sum_sat = sum_wide[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
		end else begin
			sum_sat = sum_wide[COEF_W-1:0];
		end
	end

	always_comb begin
		unique case (cmd.wr_sel)
			WS_NEW_CUR: begin
				wa = cur_q;
				wd = {coef_q, exp_q};
			end
			WS_CARRY_CUR: begin
				wa = cur_q;
				wd = carry_q;
			end
			WS_CARRY_CNT: begin
				wa = count_q[AW-1:0];
				wd = carry_q;
			end
			WS_SUM_CUR: begin
				wa = cur_q;
				wd = {sum_q, exp_q};
			end
			WS_RDATA_PREV: begin
				wa = cur_q - AW'(1);
				wd = rdata_q;
			end
			default: begin
				wa = cur_q;
				wd = carry_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wa] <= wd;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op;
			coef_q <= coefficient;
			exp_q  <= exponent;
		end
		if (cmd.carry_new) begin
			carry_q <= {coef_q, exp_q};
		end else if (cmd.carry_rdata) begin
			carry_q <= rdata_q;
		end
		if (cmd.sum_load) begin
			sum_q <= sum_sat;
		end
		if (cmd.out_load) begin
			out_term_q <= cmd.out_term ? rdata_q : '0;
			out_tv_q   <= cmd.out_term;
			out_last_q <= cmd.out_term ? st.at_end : 1'b1;
			out_drop_q <= cmd.out_term ? 1'b0 : dropped_q;
			out_cnt_q  <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			cur_q       <= '0;
			count_q     <= '0;
			dropped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q     <= '0;
				dropped_q <= 1'b0;
			end else if (cmd.rd_en) begin
				idx_q <= idx_q + CNT_W'(1);
				cur_q <= idx_q[AW-1:0];
			end
			if (cmd.set_drop) begin
				dropped_q <= 1'b1;
			end
			if (cmd.cnt_inc) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		st.op_dump  = op_q;
		st.empty    = (count_q == '0);
		st.full     = (count_q == FULL_CNT);
		// The word in rdata_q is the last stored term once the read index reaches the count.
		st.at_end   = (idx_q == count_q);
		st.exp_lt   = ($signed(rdata_q.expo) < $signed(exp_q));
		st.exp_eq   = (rdata_q.expo == exp_q);
		st.sum_zero = (sum_q == '0);
		st.out_free = !out_valid_q || !out_stall;
	end

	assign term_coefficient = out_term_q.coef;
	assign term_exponent    = out_term_q.expo;
	assign term_valid       = out_tv_q;
	assign last             = out_last_q;
	assign dropped          = out_drop_q;
	assign term_count       = out_cnt_q;
	assign out_valid        = out_valid_q;

`ifndef SYNTHESIS
	a_no_grow_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |-> count_q != FULL_CNT)
		else $error("term count grows past the table size");

	a_no_shrink_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_dec |-> count_q != '0)
		else $error("term count shrinks below zero");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> idx_q < count_q)
		else $error("read of an entry beyond the stored terms");

	a_no_overwrite_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("output word overwritten while stalled");
`endif

endmodule

>>> src/sta_ctrl.sv
// Controller state machine of the sorted term accumulator.
`timescale 1ns / 1ps

module sta_ctrl
	import sta_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  sta_status_t st,
	output sta_cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_ADD_CMP,
		S_ADD_SHIFT,
		S_ADD_END,
		S_ADD_SUM,
		S_DEL,
		S_RESULT,
		S_DUMP
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_START;
				end
			end
			S_START: begin
				priority if (st.op_dump) begin
					if (st.empty) begin
						state_d = S_RESULT;
					end else begin
						cmd.rd_en = 1'b1;
						state_d   = S_DUMP;
					end
				end else if (st.empty) begin
					cmd.carry_new = 1'b1;
					state_d       = S_ADD_END;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = S_ADD_CMP;
				end
			end
			S_ADD_CMP: begin
				priority if (st.exp_eq) begin
					cmd.sum_load = 1'b1;
					state_d      = S_ADD_SUM;
				end else if (st.exp_lt) begin
					priority if (!st.at_end) begin
						cmd.rd_en = 1'b1;
					end else if (st.full) begin
						cmd.set_drop = 1'b1;
						state_d      = S_RESULT;
					end else begin
						cmd.carry_new = 1'b1;
						state_d       = S_ADD_END;
					end
				end else if (st.full) begin
					cmd.set_drop = 1'b1;
					state_d      = S_RESULT;
				end else begin
					// New term goes here; the displaced term rides along in the carry.
					cmd.wr_en       = 1'b1;
					cmd.wr_sel      = WS_NEW_CUR;
					cmd.carry_rdata = 1'b1;
					if (st.at_end) begin
						state_d = S_ADD_END;
					end else begin
						cmd.rd_en = 1'b1;
						state_d   = S_ADD_SHIFT;
					end
				end
			end
			S_ADD_SHIFT: begin
				cmd.wr_en       = 1'b1;
				cmd.wr_sel      = WS_CARRY_CUR;
				cmd.carry_rdata = 1'b1;
				if (st.at_end) begin
					state_d = S_ADD_END;
				end else begin
					cmd.rd_en = 1'b1;
				end
			end
			S_ADD_END: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WS_CARRY_CNT;
				cmd.cnt_inc = 1'b1;
				state_d     = S_RESULT;
			end
			S_ADD_SUM: begin
				priority if (!st.sum_zero) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = WS_SUM_CUR;
					state_d    = S_RESULT;
				end else if (st.at_end) begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_RESULT;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = S_DEL;
				end
			end
			S_DEL: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WS_RDATA_PREV;
				if (st.at_end) begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_RESULT;
				end else begin
					cmd.rd_en = 1'b1;
				end
			end
			S_RESULT: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_DUMP: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_term = 1'b1;
					if (st.at_end) begin
						state_d = S_IDLE;
					end else begin
						cmd.rd_en = 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

>>> src/sorted_term_accumulator.sv
// Top level of the sorted term accumulator: controller and datapath.
// An add word yields its status word after a walk through the term memory, which reads
// one entry per cycle on its single read port.
// A dump word yields one word per cycle while the output is not stalled.
// A new word is accepted in the cycle after the previous one's last word is registered.
// Reset empties the table at once; memory contents are not cleared and no sweep runs.
`timescale 1ns / 1ps

module sorted_term_accumulator
	import sta_pkg::*;
#(
	parameter int MAX_TERMS = DEF_MAX_TERMS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     op,
	input  logic signed [COEF_W-1:0] coefficient,
	input  logic signed [EXP_W-1:0]  exponent,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [COEF_W-1:0] term_coefficient,
	output logic signed [EXP_W-1:0]  term_exponent,
	output logic                     term_valid,
	output logic                     last,
	output logic                     dropped,
	output logic [CNT_W-1:0]         term_count
);

	sta_cmd_t    cmd;
	sta_status_t st;

	sta_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	sta_dp #(
		.MAX_TERMS (MAX_TERMS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.st               (st),
		.op               (op),
		.coefficient      (coefficient),
		.exponent         (exponent),
		.term_coefficient (term_coefficient),
		.term_exponent    (term_exponent),
		.term_valid       (term_valid),
		.last             (last),
		.dropped          (dropped),
		.term_count       (term_count),
		.out_valid        (out_valid),
		.out_stall        (out_stall)
	);

endmodule

>>> tb/sv/tb_sorted_term_accumulator.sv
// Testbench of the sorted term accumulator: directed and random words checked against a shadow table.
`timescale 1ns / 1ps

module tb_sorted_term_accumulator;
	import sta_pkg::*;

	localparam int MAX_TERMS   = DEF_MAX_TERMS;
	localparam int QUIET_LIMIT = 3000;
	localparam int SETTLE      = 2 * MAX_TERMS + 16;
	localparam int REPORT_CAP  = 100;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_DUMP = 1'b1;

	localparam logic signed [COEF_W-1:0] COEF_TOP = 32'sh7fffffff;
	localparam logic signed [COEF_W-1:0] COEF_BOT = 32'sh80000000;
	localparam logic signed [EXP_W-1:0]  EXP_TOP  = 16'sh7fff;
	localparam logic signed [EXP_W-1:0]  EXP_BOT  = 16'sh8000;

	typedef struct packed {
		logic signed [COEF_W-1:0] coef;
		logic signed [EXP_W-1:0]  expo;
		logic                     has_term;
		logic                     is_last;
		logic                     was_dropped;
		logic [CNT_W-1:0]         count;
	} result_word_t;

	logic                     clk         = 1'b0;
	logic                     arst_n      = 1'b0;
	logic                     in_valid    = 1'b0;
	logic                     in_stall;
	logic                     op          = 1'b0;
	logic signed [COEF_W-1:0] coefficient = '0;
	logic signed [EXP_W-1:0]  exponent    = '0;
	logic                     out_valid;
	logic                     out_stall   = 1'b0;
	logic signed [COEF_W-1:0] term_coefficient;
	logic signed [EXP_W-1:0]  term_exponent;
	logic                     term_valid;
	logic                     last;
	logic                     dropped;
	logic [CNT_W-1:0]         term_count;

	// Shadow copy of the term table, kept in step with every accepted word.
	logic signed [COEF_W-1:0] shadow_coef [MAX_TERMS];
	logic signed [EXP_W-1:0]  shadow_exp  [MAX_TERMS];
	int                       shadow_len = 0;
	result_word_t             awaited_words [$];

	int fail_count      = 0;
	bit sender_idle_on  = 1'b1;
	bit receiver_idle_on = 1'b1;
	int hold_request    = 0;
	int stall_left      = 0;

	sorted_term_accumulator #(
		.MAX_TERMS(MAX_TERMS)
	) u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.op              (op),
		.coefficient     (coefficient),
		.exponent        (exponent),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.term_coefficient(term_coefficient),
		.term_exponent   (term_exponent),
		.term_valid      (term_valid),
		.last            (last),
		.dropped         (dropped),
		.term_count      (term_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Updates the shadow table for one accepted word and queues the words it must produce.
	function automatic void step_term_table(input logic word_op,
			input logic signed [COEF_W-1:0] c, input logic signed [EXP_W-1:0] e);
		int           pos;
		int           i;
		longint       acc;
		result_word_t w;
		w = '0;
		if (word_op == OP_ADD) begin
			pos = 0;
			while (pos < shadow_len && shadow_exp[pos] < e)
				pos++;
			if (pos < shadow_len && shadow_exp[pos] == e) begin
				acc = longint'(shadow_coef[pos]) + longint'(c);
				if (acc > longint'(COEF_TOP))
					acc = longint'(COEF_TOP);
				if (acc < longint'(COEF_BOT))
					acc = longint'(COEF_BOT);
				if (acc == 0) begin
					for (i = pos; i + 1 < shadow_len; i++) begin
						shadow_coef[i] = shadow_coef[i + 1];
						shadow_exp[i]  = shadow_exp[i + 1];
					end
					shadow_len--;
				end else begin
					shadow_coef[pos] = COEF_W'(acc);
				end
			end else if (shadow_len >= MAX_TERMS) begin
				w.was_dropped = 1'b1;
			end else begin
				for (i = shadow_len; i > pos; i--) begin
					shadow_coef[i] = shadow_coef[i - 1];
					shadow_exp[i]  = shadow_exp[i - 1];
				end
				shadow_coef[pos] = c;
				shadow_exp[pos]  = e;
				shadow_len++;
			end
			w.is_last = 1'b1;
			w.count   = CNT_W'(shadow_len);
			awaited_words.push_back(w);
		end else if (shadow_len == 0) begin
			w.is_last = 1'b1;
			awaited_words.push_back(w);
		end else begin
			for (i = 0; i < shadow_len; i++) begin
				w.coef     = shadow_coef[i];
				w.expo     = shadow_exp[i];
				w.has_term = 1'b1;
				w.is_last  = (i + 1 == shadow_len);
				w.count    = CNT_W'(shadow_len);
				awaited_words.push_back(w);
			end
		end
	endfunction

	function automatic void compare_field(input string name, input longint want, input longint got);
		if (want != got) begin
			if (fail_count < REPORT_CAP)
				$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// Input and output monitor; both sample the values in effect at the clock edge.
	always @(posedge clk) begin
		result_word_t w;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (awaited_words.size() == 0) begin
				if (fail_count < REPORT_CAP)
					$error("result word with no expectation pending");
				fail_count++;
			end else begin
				w = awaited_words.pop_front();
				compare_field("term_coefficient", w.coef, term_coefficient);
				compare_field("term_exponent", w.expo, term_exponent);
				compare_field("term_valid", w.has_term, term_valid);
				compare_field("last", w.is_last, last);
				compare_field("dropped", w.was_dropped, dropped);
				compare_field("term_count", w.count, term_count);
			end
		end
		if (arst_n && in_valid && in_stall === 1'b0)
			step_term_table(op, coefficient, exponent);
	end

	// Receiver: random stall bursts, plus one long hold when a test asks for it.
	always @(posedge clk) begin
		if (hold_request > 0) begin
			stall_left   = hold_request;
			hold_request = 0;
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (receiver_idle_on && $urandom_range(0, 4) == 0) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 6);
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("simulation failed");
		$finish;
	end

	// Offers one word and returns in the time step in which it is accepted.
	task automatic send_word(input logic word_op, input logic signed [COEF_W-1:0] c,
			input logic signed [EXP_W-1:0] e);
		if (sender_idle_on && $urandom_range(0, 3) == 0) begin
			in_valid    <= 1'b0;
			op          <= 1'($urandom);
			coefficient <= $urandom;
			exponent    <= 16'($urandom);
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		op          <= word_op;
		coefficient <= c;
		exponent    <= e;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
	endtask

	task automatic add_term(input logic signed [COEF_W-1:0] c, input logic signed [EXP_W-1:0] e);
		send_word(OP_ADD, c, e);
	endtask

	// The payload of a dump is ignored, so it carries random bits.
	task automatic dump_terms();
		send_word(OP_DUMP, $urandom, 16'($urandom));
	endtask

	// Sender pause: nothing is offered until every pending result word has come.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited_words.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [EXP_W-1:0] fresh_exponent(ref bit taken [int]);
		logic signed [EXP_W-1:0] e;
		e = 16'($urandom);
		while (taken.exists(int'(e)))
			e = 16'($urandom);
		taken[int'(e)] = 1'b1;
		return e;
	endfunction

	// Cancels one stored term; the most negative coefficient needs two steps.
	task automatic cancel_term(input logic signed [COEF_W-1:0] c, input logic signed [EXP_W-1:0] e);
		if (c == COEF_BOT) begin
			add_term(COEF_TOP, e);
			add_term(32'sd1, e);
		end else begin
			add_term(-c, e);
		end
	endtask

	task automatic clear_table();
		logic signed [COEF_W-1:0] snap_c [MAX_TERMS];
		logic signed [EXP_W-1:0]  snap_e [MAX_TERMS];
		int                       n;
		int                       i;
		wait_drained();
		n = shadow_len;
		for (i = 0; i < n; i++) begin
			snap_c[i] = shadow_coef[i];
			snap_e[i] = shadow_exp[i];
		end
		for (i = 0; i < n; i++)
			cancel_term(snap_c[i], snap_e[i]);
	endtask

	function automatic logic signed [COEF_W-1:0] random_coef();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 5)
			return COEF_W'(int'($urandom_range(0, 6)) - 3);
		else if (pick == 5)
			return COEF_TOP;
		else if (pick == 6)
			return COEF_BOT;
		else
			return $urandom;
	endfunction

	task automatic test_empty_dump();
		dump_terms();
	endtask

	task automatic test_field_extremes();
		add_term(COEF_TOP, EXP_TOP);
		add_term(COEF_BOT, EXP_BOT);
		add_term(32'sd0, 16'sd0);
		add_term(32'sd5, -16'sd1);
		add_term(32'sd3, 16'sd1);
		dump_terms();
	endtask

	task automatic test_saturation_and_removal();
		add_term(COEF_TOP, EXP_TOP);
		add_term(COEF_BOT, EXP_BOT);
		add_term(-32'sd5, -16'sd1);
		// Adding zero to a stored zero coefficient sums to zero and removes it.
		add_term(32'sd0, 16'sd0);
		add_term(32'sd1, 16'sd1);
		add_term(-COEF_TOP, EXP_TOP);
		add_term(COEF_TOP, EXP_BOT);
		add_term(32'sd1, EXP_BOT);
		dump_terms();
	endtask

	task automatic test_table_full();
		bit taken [int];
		int n;
		int i;
		wait_drained();
		for (i = 0; i < shadow_len; i++)
			taken[int'(shadow_exp[i])] = 1'b1;
		for (n = shadow_len; n < MAX_TERMS; n++)
			add_term($urandom, fresh_exponent(taken));
		add_term($urandom, fresh_exponent(taken));
		add_term(32'sd0, fresh_exponent(taken));
		dump_terms();
		wait_drained();
		// An existing exponent still accumulates while the table is full.
		i = $urandom_range(0, MAX_TERMS - 1);
		add_term(32'sd1, shadow_exp[i]);
		wait_drained();
		i = $urandom_range(0, shadow_len - 1);
		cancel_term(shadow_coef[i], shadow_exp[i]);
		add_term($urandom, fresh_exponent(taken));
		add_term($urandom, fresh_exponent(taken));
		dump_terms();
	endtask

	task automatic test_backpressure();
		int i;
		sender_idle_on = 1'b0;
		hold_request   = 300;
		for (i = 0; i < 30; i++) begin
			if ($urandom_range(0, 2) == 0)
				dump_terms();
			else
				add_term(random_coef(), 16'(int'($urandom_range(0, 8)) - 4));
		end
		sender_idle_on = 1'b1;
		wait_drained();
	endtask

	task automatic test_random_mix(input int words);
		int i;
		int pick;
		for (i = 0; i < words; i++) begin
			if (i % 110 == 0)
				clear_table();
			pick = $urandom_range(0, 99);
			if (pick < 10)
				dump_terms();
			else if (pick < 55)
				add_term(COEF_W'(int'($urandom_range(0, 6)) - 3),
					16'(int'($urandom_range(0, 8)) - 4));
			else if (pick < 70)
				add_term(random_coef(), 16'(int'($urandom_range(0, 8)) - 4));
			else if (pick < 85)
				add_term($urandom, 16'($urandom));
			else
				add_term(random_coef(), 16'(int'($urandom_range(0, 120)) - 60));
		end
		dump_terms();
	endtask

	task automatic test_closing_without_idle();
		int i;
		sender_idle_on   = 1'b0;
		receiver_idle_on = 1'b0;
		clear_table();
		for (i = 0; i < 30; i++) begin
			if (i % 10 == 9)
				dump_terms();
			else
				add_term(random_coef(), 16'(int'($urandom_range(0, 12)) - 6));
		end
		dump_terms();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_dump();
		test_field_extremes();
		test_saturation_and_removal();
		test_table_full();
		test_backpressure();
		test_random_mix(180);
		test_closing_without_idle();
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
